// ===== design/udps_pkg.sv =====
// Shared types and constants for the unordered pair duplicate filter.
// No dependencies; used by every module of the block.
`default_nettype none

package udps_pkg;

    // Default configuration of the store.
    localparam int UDPS_CAPACITY   = 64;
    localparam int UDPS_STATE_BITS = 64;

    // Fixed widths of the request and result fields.
    localparam int UDPS_FIELD_W = 64;
    localparam int UDPS_COUNT_W = 7;

    // Control tag that travels with a request along the cell chain.
    typedef struct packed {
        logic vld;  // a request occupies this stage
        logic hit;  // some cell already held the pair
        logic ins;  // some cell took the pair as a new entry
    } udps_tag_t;

endpackage

`default_nettype wire

// ===== design/udps_order.sv =====
// Entry stage: trims both states to the stored width and orders them.
// Depends on udps_pkg.
`default_nettype none

module udps_order #(
    parameter int STATE_BITS = udps_pkg::UDPS_STATE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire logic                              take,
    input  wire logic [udps_pkg::UDPS_FIELD_W-1:0] first_state,
    input  wire logic [udps_pkg::UDPS_FIELD_W-1:0] second_state,
    output udps_pkg::udps_tag_t                    tag_out,
    output logic [STATE_BITS-1:0]                  lo_out,
    output logic [STATE_BITS-1:0]                  hi_out
);
    import udps_pkg::*;

    logic [STATE_BITS-1:0] a_val;
    logic [STATE_BITS-1:0] b_val;
    logic [STATE_BITS-1:0] lo_next;
    logic [STATE_BITS-1:0] hi_next;
    udps_tag_t             tag_reg;
    udps_tag_t             tag_next;
    logic [STATE_BITS-1:0] lo_reg;
    logic [STATE_BITS-1:0] hi_reg;

    always_comb
    begin
        a_val        = first_state[STATE_BITS-1:0];
        b_val        = second_state[STATE_BITS-1:0];
        lo_next      = (b_val >= a_val) ? a_val : b_val;
        hi_next      = (b_val >= a_val) ? b_val : a_val;
        tag_next.vld = take;
        tag_next.hit = 1'b0;
        tag_next.ins = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (adv)
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign tag_out = tag_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;

endmodule

`default_nettype wire

// ===== design/udps_cell.sv =====
// One slot of the pair store plus one stage of the request chain.
// Depends on udps_pkg.
`default_nettype none

module udps_cell #(
    parameter int STATE_BITS = udps_pkg::UDPS_STATE_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire udps_pkg::udps_tag_t   tag_in,
    input  wire logic [STATE_BITS-1:0] lo_in,
    input  wire logic [STATE_BITS-1:0] hi_in,
    output udps_pkg::udps_tag_t        tag_out,
    output logic [STATE_BITS-1:0]      lo_out,
    output logic [STATE_BITS-1:0]      hi_out
);
    import udps_pkg::*;

    logic                  slot_valid_reg;
    logic [STATE_BITS-1:0] slot_lo_reg;
    logic [STATE_BITS-1:0] slot_hi_reg;
    udps_tag_t             tag_reg;
    udps_tag_t             tag_next;
    logic [STATE_BITS-1:0] lo_reg;
    logic [STATE_BITS-1:0] hi_reg;
    logic                  match;
    logic                  store;

    // Slots fill in order, so the first empty slot a new pair meets is the next free one.
    always_comb
    begin
        match        = slot_valid_reg && (slot_lo_reg == lo_in) && (slot_hi_reg == hi_in);
        store        = tag_in.vld && !tag_in.hit && !tag_in.ins && !slot_valid_reg;
        tag_next.vld = tag_in.vld;
        tag_next.hit = tag_in.vld && (tag_in.hit || match);
        tag_next.ins = tag_in.vld && (tag_in.ins || store);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg        <= '0;
            slot_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag_reg <= tag_next;
            if (store)
            begin
                slot_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= lo_in;
            hi_reg <= hi_in;
            if (store)
            begin
                slot_lo_reg <= lo_in;
                slot_hi_reg <= hi_in;
            end
        end
    end

    assign tag_out = tag_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;

endmodule

`default_nettype wire

// ===== design/unordered_pair_dedup_set.sv =====
// Top level of the unordered pair duplicate filter: entry stage, cell chain, result register.
// Depends on udps_pkg, udps_order and udps_cell.
//
//   Channel   | Handshake            | Payload
//   ----------+----------------------+---------------------------------------------
//   request   | in_valid, in_stall   | first_state, second_state
//   result    | out_valid, out_stall | was_new, dropped_full, distinct_count
//
// A new request can be taken in every cycle in which in_stall is low. Its result passes
// through the ordering stage, then each store cell, then the result register, so the
// length of the cell chain sets the latency.
// Reset clears the valid mark of every slot and the count at once; there is no clearing pass.
// While a result waits under out_stall the whole chain holds and in_stall is raised.
`default_nettype none

module unordered_pair_dedup_set #(
    parameter int CAPACITY   = udps_pkg::UDPS_CAPACITY,
    parameter int STATE_BITS = udps_pkg::UDPS_STATE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [udps_pkg::UDPS_FIELD_W-1:0] first_state,
    input  wire logic [udps_pkg::UDPS_FIELD_W-1:0] second_state,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   was_new,
    output logic                                   dropped_full,
    output logic [udps_pkg::UDPS_COUNT_W-1:0]      distinct_count
);
    import udps_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The chain moves as a whole; it holds only when a finished result is not taken.
    logic adv;

    // Stage k of these arrays feeds cell k; the last stage leaves the chain.
    udps_tag_t             tag_chain [0:CAPACITY];
    logic [STATE_BITS-1:0] lo_chain  [0:CAPACITY];
    logic [STATE_BITS-1:0] hi_chain  [0:CAPACITY];

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      was_new_reg;
    logic                      was_new_next;
    logic                      dropped_reg;
    logic                      dropped_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W+UDPS_COUNT_W-1:0] count_wide;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Masking and ordering of the two states happen before the store is searched.
    udps_order #(
        .STATE_BITS (STATE_BITS)
    ) u_order (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .take         (in_valid),
        .first_state  (first_state),
        .second_state (second_state),
        .tag_out      (tag_chain[0]),
        .lo_out       (lo_chain[0]),
        .hi_out       (hi_chain[0])
    );

    // Each request walks past every slot. A slot holding the same pair marks it as a
    // duplicate; the first empty slot reached by a pair not yet marked takes it. Because
    // requests stay in order and never share a stage, a later request always sees what an
    // earlier one wrote.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        udps_cell #(
            .STATE_BITS (STATE_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tag_in  (tag_chain[gi]),
            .lo_in   (lo_chain[gi]),
            .hi_in   (hi_chain[gi]),
            .tag_out (tag_chain[gi+1]),
            .lo_out  (lo_chain[gi+1]),
            .hi_out  (hi_chain[gi+1])
        );
    end

    // A request that leaves the chain neither matched nor stored found the store full.
    // Results leave in request order, so a running count here equals the filled slots.
    always_comb
    begin
        out_valid_next = tag_chain[CAPACITY].vld;
        was_new_next   = tag_chain[CAPACITY].ins;
        dropped_next   = !tag_chain[CAPACITY].hit && !tag_chain[CAPACITY].ins;
        count_next     = count_reg + CNT_W'(tag_chain[CAPACITY].ins);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
            if (out_valid_next)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && out_valid_next)
        begin
            was_new_reg <= was_new_next;
            dropped_reg <= dropped_next;
        end
    end

    // The count is widened and cut to the result field, so only its low UDPS_COUNT_W bits are reported.
    assign count_wide     = {{UDPS_COUNT_W{1'b0}}, count_reg};
    assign out_valid      = out_valid_reg;
    assign was_new        = was_new_reg;
    assign dropped_full   = dropped_reg;
    assign distinct_count = count_wide[UDPS_COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== design/udps_checker.sv =====
// Port-level checks for the unordered pair duplicate filter, and their binding.
// Depends on udps_pkg and the top level unordered_pair_dedup_set.
`default_nettype none

module udps_checker #(
    parameter int CAPACITY = udps_pkg::UDPS_CAPACITY
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              was_new,
    input wire logic                              dropped_full,
    input wire logic [udps_pkg::UDPS_COUNT_W-1:0] distinct_count
);
    import udps_pkg::*;

    localparam logic [UDPS_COUNT_W-1:0] FULL_COUNT = UDPS_COUNT_W'(CAPACITY);

    // A waiting result keeps its count.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distinct_count))
        else $error("result changed while stalled");

    // A result cannot be both a stored pair and a dropped one.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_new && dropped_full))
        else $error("was_new and dropped_full together");

    // A pair is dropped only once every slot is taken.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_full |-> distinct_count == FULL_COUNT)
        else $error("pair dropped while store not full");

    // A blocked result freezes the chain, so no request enters.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request side open while result blocked");

    // When a taken result is followed by one that holds no new pair, the count stays unchanged.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid && !was_new |->
        distinct_count == $past(distinct_count))
        else $error("count moved without a new pair");

endmodule

bind unordered_pair_dedup_set udps_checker #(
    .CAPACITY (CAPACITY)
) u_udps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .was_new        (was_new),
    .dropped_full   (dropped_full),
    .distinct_count (distinct_count)
);

`default_nettype wire
